[sv/srit_pkg.sv]
// shared types and constants of the sorted record insert table
package srit_pkg;

  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned KEY_LETTERS_DEF = 10;
  localparam int unsigned COORD_BITS_DEF  = 8;
  localparam int unsigned LETTER_BITS     = 5;

  localparam int unsigned KEY_PORT_W   = 50;
  localparam int unsigned COORD_PORT_W = 8;
  localparam int unsigned RANK_W       = 6;
  localparam int unsigned ID_W         = 7;
  localparam int unsigned FILL_W       = 7;
  localparam int unsigned STATUS_W     = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANK = 2'd2;

  typedef struct packed {
    logic                in_rdy;
    logic                load;
    logic                rd_top;
    logic                rd_rank;
    logic                rd_prev;
    logic                wr_shift;
    logic                wr_new_up;
    logic                wr_new_head;
    logic                emit;
    logic                emit_read;
    logic [STATUS_W-1:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic op;
    logic full;
    logic empty;
    logic rank_miss;
    logic gt;
    logic ptr_zero;
    logic out_free;
  } sts_t;

endpackage

[sv/srit_if.sv]
// input and result channel interfaces of the sorted record insert table
interface srit_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [srit_pkg::KEY_PORT_W-1:0]   key;
  logic [srit_pkg::COORD_PORT_W-1:0] shelf_row;
  logic [srit_pkg::COORD_PORT_W-1:0] shelf_column;
  logic [srit_pkg::COORD_PORT_W-1:0] place_in_shelf;
  logic [srit_pkg::RANK_W-1:0]       rank;

  modport source (output valid, op, key, shelf_row, shelf_column, place_in_shelf, rank,
                  input ready);
  modport sink (input valid, op, key, shelf_row, shelf_column, place_in_shelf, rank,
                output ready);
endinterface

interface srit_out_if;
  logic                              valid;
  logic                              ready;
  logic [srit_pkg::STATUS_W-1:0]     status;
  logic [srit_pkg::ID_W-1:0]         record_id;
  logic [srit_pkg::KEY_PORT_W-1:0]   out_key;
  logic [srit_pkg::COORD_PORT_W-1:0] out_row;
  logic [srit_pkg::COORD_PORT_W-1:0] out_column;
  logic [srit_pkg::COORD_PORT_W-1:0] out_place;
  logic [srit_pkg::FILL_W-1:0]       fill_count;

  modport source (output valid, status, record_id, out_key, out_row, out_column, out_place,
                  fill_count, input ready);
  modport sink (input valid, status, record_id, out_key, out_row, out_column, out_place,
                fill_count, output ready);
endinterface

[sv/srit_ctrl.sv]
// controller state machine of the sorted record insert table
module srit_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  srit_pkg::sts_t sts,
  output srit_pkg::cmd_t cmd
);
  import srit_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]          state, state_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic                res_read, res_read_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_OK;
      res_read   <= 1'b0;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_read   <= res_read_next;
    end
  end

  always_comb begin
    cmd             = '0;
    state_next      = state;
    res_status_next = res_status;
    res_read_next   = res_read;
    unique case (state)
      S_IDLE: begin
        cmd.in_rdy = 1'b1;
        if (sts.in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        res_status_next = ST_OK;
        res_read_next   = 1'b0;
        if (sts.op == OP_INSERT) begin
          if (sts.full) begin
            res_status_next = ST_FULL;
            state_next      = S_EMIT;
          end else if (sts.empty) begin
            cmd.wr_new_head = 1'b1;
            state_next      = S_EMIT;
          end else begin
            cmd.rd_top = 1'b1;
            state_next = S_SCAN;
          end
        end else begin
          if (sts.rank_miss) begin
            res_status_next = ST_RANK;
          end else begin
            cmd.rd_rank   = 1'b1;
            res_read_next = 1'b1;
          end
          state_next = S_EMIT;
        end
      end
      S_SCAN: begin
        if (sts.gt) begin
          cmd.wr_shift = 1'b1;
          if (sts.ptr_zero) begin
            state_next = S_PLACE;
          end else begin
            cmd.rd_prev = 1'b1;
          end
        end else begin
          cmd.wr_new_up = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_PLACE: begin
        cmd.wr_new_head = 1'b1;
        state_next      = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_status = res_status;
        cmd.emit_read   = res_read;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[sv/srit_dp.sv]
// datapath of the sorted record insert table: record memory, counters, result register
module srit_dp #(
  parameter int unsigned CAPACITY    = srit_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_LETTERS = srit_pkg::KEY_LETTERS_DEF,
  parameter int unsigned COORD_BITS  = srit_pkg::COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  srit_pkg::cmd_t cmd,
  output srit_pkg::sts_t sts,
  srit_in_if.sink        in_ch,
  srit_out_if.source     out_ch
);
  import srit_pkg::*;

  localparam int unsigned KW_FULL = KEY_LETTERS * LETTER_BITS;
  localparam int unsigned KW      = (KW_FULL < KEY_PORT_W) ? KW_FULL : KEY_PORT_W;
  localparam int unsigned CW      = (COORD_BITS < COORD_PORT_W) ? COORD_BITS : COORD_PORT_W;
  localparam int unsigned LW      = 3 * CW;
  localparam int unsigned AW      = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned RW      = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  logic [KW-1:0]   mem_key [CAPACITY];
  logic [LW-1:0]   mem_loc [CAPACITY];
  logic [ID_W-1:0] mem_id  [CAPACITY];

  logic              item_op;
  logic [KW-1:0]     item_key;
  logic [LW-1:0]     item_loc;
  logic [RANK_W-1:0] item_rank;

  logic [KW-1:0]   rd_key;
  logic [LW-1:0]   rd_loc;
  logic [ID_W-1:0] rd_id;

  logic [CNT_W-1:0] count;
  logic [ID_W-1:0]  id_counter;
  logic [AW-1:0]    ptr;

  logic            rd_en, wr_en, wr_new;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [KW-1:0]   wr_key;
  logic [LW-1:0]   wr_loc;
  logic [ID_W-1:0] wr_id;
  logic [ID_W-1:0] id_inc;

  logic                    out_valid;
  logic [STATUS_W-1:0]     out_status;
  logic [ID_W-1:0]         out_id;
  logic [KEY_PORT_W-1:0]   out_key;
  logic [COORD_PORT_W-1:0] out_row, out_col, out_place;
  logic [FILL_W-1:0]       out_fill;

  // accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op   <= in_ch.op;
      item_key  <= in_ch.key[KW-1:0];
      item_loc  <= {in_ch.shelf_row[CW-1:0], in_ch.shelf_column[CW-1:0],
                    in_ch.place_in_shelf[CW-1:0]};
      item_rank <= in_ch.rank;
    end
  end

  assign id_inc = id_counter + 1'b1;
  assign wr_new = cmd.wr_new_up | cmd.wr_new_head;
  assign wr_en  = cmd.wr_shift | wr_new;
  assign rd_en  = cmd.rd_top | cmd.rd_rank | cmd.rd_prev;

  always_comb begin
    priority if (cmd.rd_top) begin
      rd_addr = AW'(count - 1'b1);
    end else if (cmd.rd_rank) begin
      rd_addr = AW'(item_rank);
    end else begin
      rd_addr = ptr - 1'b1;
    end
  end

  assign wr_addr = cmd.wr_new_head ? '0 : ptr + 1'b1;
  assign wr_key  = cmd.wr_shift ? rd_key : item_key;
  assign wr_loc  = cmd.wr_shift ? rd_loc : item_loc;
  assign wr_id   = cmd.wr_shift ? rd_id  : id_inc;

  // record memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_loc[wr_addr] <= wr_loc;
      mem_id[wr_addr]  <= wr_id;
    end
    if (rd_en) begin
      rd_key <= mem_key[rd_addr];
      rd_loc <= mem_loc[rd_addr];
      rd_id  <= mem_id[rd_addr];
    end
  end

  // scan pointer follows the record held in the read register
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ptr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      id_counter <= '0;
    end else if (wr_new) begin
      count      <= count + 1'b1;
      id_counter <= id_inc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.emit_status;
      out_fill   <= FILL_W'(count);
      if (cmd.emit_read) begin
        out_id    <= rd_id;
        out_key   <= KEY_PORT_W'(rd_key);
        out_row   <= COORD_PORT_W'(rd_loc[LW-1:2*CW]);
        out_col   <= COORD_PORT_W'(rd_loc[2*CW-1:CW]);
        out_place <= COORD_PORT_W'(rd_loc[CW-1:0]);
      end else begin
        out_id    <= (cmd.emit_status == ST_OK) ? id_counter : '0;
        out_key   <= '0;
        out_row   <= '0;
        out_col   <= '0;
        out_place <= '0;
      end
    end
  end

  assign in_ch.ready       = cmd.in_rdy;
  assign out_ch.valid      = out_valid;
  assign out_ch.status     = out_status;
  assign out_ch.record_id  = out_id;
  assign out_ch.out_key    = out_key;
  assign out_ch.out_row    = out_row;
  assign out_ch.out_column = out_col;
  assign out_ch.out_place  = out_place;
  assign out_ch.fill_count = out_fill;

  assign sts.in_valid  = in_ch.valid;
  assign sts.op        = item_op;
  assign sts.full      = (count == CNT_W'(CAPACITY));
  assign sts.empty     = (count == '0);
  assign sts.rank_miss = (RW'(item_rank) >= RW'(count));
  assign sts.gt        = (rd_key > item_key);
  assign sts.ptr_zero  = (ptr == '0);
  assign sts.out_free  = !out_valid || out_ch.ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("record count above capacity");

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_new_up || cmd.wr_new_head) |-> !sts.full)
    else $error("record written into a full table");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result register overwritten before its beat");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_new_up || cmd.wr_new_head) |=> count == CNT_W'($past(count) + 1'b1))
    else $error("record count did not advance on insert");

endmodule

[sv/sorted_record_insert_table_unit.sv]
// top level of the sorted record insert table
// Keeps up to CAPACITY records in ascending key order in a single-port-write record memory
// with a registered read. One item is worked at a time and each beat in gives one beat out.
// A read, a rank miss, a dropped insert into a full table and an insert into an empty table
// go from accept through the start state straight to the result; an insert into a non-empty
// table first scans down from the last record past every stored record with a greater key,
// moving one record up per cycle through the memory port, then writes the new record. The
// next item is taken in the cycle after the result enters the output register, which then
// holds it until the sink takes the beat. The table is empty right after reset.
module sorted_record_insert_table_unit #(
  parameter int unsigned CAPACITY    = srit_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_LETTERS = srit_pkg::KEY_LETTERS_DEF,
  parameter int unsigned COORD_BITS  = srit_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  srit_in_if.sink    in_ch,
  srit_out_if.source out_ch
);
  import srit_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srit_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  srit_dp #(
    .CAPACITY    (CAPACITY),
    .KEY_LETTERS (KEY_LETTERS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
